FILE: rtl/core/aalb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and controller/datapath handshake types.
package aalb_pkg;

    localparam int DEF_WINDOW_LENGTH       = 50;
    localparam int DEF_PERIODS_PER_AVERAGE = 10;
    localparam int DEF_SAMPLE_BITS         = 10;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int BRIGHT_W   = 8;
    localparam int PCT_DIV    = 100;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = '1;
    localparam logic [BRIGHT_W-1:0] BRIGHT_ZERO = '0;

    localparam logic [CFG_IDX_W-1:0] REG_VALLEY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PEAK   = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] VALLEY_RST = CFG_DATA_W'(70);
    localparam logic [CFG_DATA_W-1:0] PEAK_RST   = CFG_DATA_W'(190);

    typedef struct packed {
        logic accept;
        logic lo_start;
        logic lo_take;
        logic hi_start;
        logic hi_take;
        logic span_load;
        logic br_eval;
        logic br_take;
        logic blk_step;
        logic win_update;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic fill;
        logic div_idle;
        logic br_direct;
        logic blk_full;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/aalb_if.sv
`timescale 1ns / 1ps
// Channel interfaces: sample input, result output and register write port.
interface aalb_in_if import aalb_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   period_end;

    modport source (output valid, sample, period_end, input ready);
    modport sink   (input valid, sample, period_end, output ready);
endinterface

interface aalb_out_if import aalb_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [BRIGHT_W-1:0]    brightness;
    logic [SAMPLE_BITS-1:0] volume;
    logic                   calibrating;

    modport source (output valid, brightness, volume, calibrating, input ready);
    modport sink   (input valid, brightness, volume, calibrating, output ready);
endinterface

interface aalb_cfg_if import aalb_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/aalb_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
module aalb_div #(
    parameter int DV_W,
    parameter int DS_W,
    parameter int STEP_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [STEP_W-1:0] i_steps,
    input  logic [DS_W-1:0]   i_rem,
    input  logic [DV_W-1:0]   i_quo,
    input  logic [DS_W-1:0]   i_dvs,
    output logic              o_idle,
    output logic [DV_W-1:0]   o_quo
);

    logic [DS_W-1:0]   r_rem, n_rem;
    logic [DV_W-1:0]   r_quo, n_quo;
    logic [DS_W-1:0]   r_dvs, n_dvs;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DS_W:0]     w_shift;
    logic [DS_W:0]     w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[DV_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_rem = i_rem;
            n_quo = i_quo;
            n_dvs = i_dvs;
            n_cnt = i_steps;
        end else if (r_cnt != '0) begin
            // top bit of the difference is the borrow
            if (!w_diff[DS_W]) begin
                n_rem = w_diff[DS_W-1:0];
                n_quo = {r_quo[DV_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DS_W-1:0];
                n_quo = {r_quo[DV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_idle = (r_cnt == '0);
    assign o_quo  = r_quo;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && (i_steps != '0) |=> !o_idle)
        else $error("divider idle after start");

endmodule

FILE: rtl/core/aalb_dp.sv
`timescale 1ns / 1ps
// Datapath: envelope tracking, block average, window memory, bounds and output register.
module aalb_dp import aalb_pkg::*; #(
    parameter int WINDOW_LENGTH,
    parameter int PERIODS_PER_AVERAGE,
    parameter int SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_period_end,
    aalb_out_if.source             o_out,
    aalb_cfg_if.sink               i_cfg
);

    localparam int PTR_W  = $clog2(WINDOW_LENGTH);
    localparam int CNT_W  = $clog2(PERIODS_PER_AVERAGE + 1);
    localparam int BSUM_W = SAMPLE_BITS + $clog2(PERIODS_PER_AVERAGE);
    localparam int RS_W   = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
    localparam int LO_W   = RS_W + 2;
    localparam int DS_W   = RS_W + 3;
    localparam int PROD_W = RS_W + CFG_DATA_W;
    localparam int DV_W   = BRIGHT_W;
    localparam int STEP_W = $clog2(DV_W + 1);
    localparam int BD_W   = DS_W + BRIGHT_W;

    // exact floor division by a constant: multiply by rounded-up reciprocal, then shift
    localparam int PCT_SH = PROD_W + $clog2(PCT_DIV);
    localparam int PRCP_W = PROD_W + 1;
    localparam int PMUL_W = 2 * PROD_W + 1;
    localparam int AVG_SH = BSUM_W + $clog2(PERIODS_PER_AVERAGE);
    localparam int ARCP_W = BSUM_W + 1;
    localparam int AMUL_W = 2 * BSUM_W + 1;
    localparam logic [PRCP_W-1:0] PCT_RCP =
        PRCP_W'(((64'd1 << PCT_SH) + 64'(PCT_DIV - 1)) / 64'(PCT_DIV));
    localparam logic [ARCP_W-1:0] AVG_RCP =
        ARCP_W'(((64'd1 << AVG_SH) + 64'(PERIODS_PER_AVERAGE - 1))
                / 64'(PERIODS_PER_AVERAGE));

    // configuration
    logic [CFG_DATA_W-1:0] r_valley;
    logic [CFG_DATA_W-1:0] r_peak;

    // model state
    logic [SAMPLE_BITS-1:0] r_pk;
    logic [SAMPLE_BITS-1:0] r_tr;
    logic [BSUM_W-1:0]      r_bsum;
    logic [CNT_W-1:0]       r_cnt;
    logic [PTR_W-1:0]       r_ptr;
    logic [RS_W-1:0]        r_rs;
    logic                   r_fill;
    logic [SAMPLE_BITS-1:0] r_win [WINDOW_LENGTH];

    // per-item working registers
    logic [SAMPLE_BITS-1:0] r_vol;
    logic                   r_cal;
    logic [RS_W-1:0]        r_x;
    logic [PROD_W-1:0]      r_prod;
    logic [LO_W-1:0]        r_lo;
    logic [LO_W-1:0]        r_hi;
    logic signed [DS_W-1:0] r_num;
    logic signed [DS_W-1:0] r_den;
    logic [BRIGHT_W-1:0]    r_bright;
    logic [SAMPLE_BITS-1:0] r_rd;

    // output register
    logic                   r_ovalid;
    logic [BRIGHT_W-1:0]    r_obright;
    logic [SAMPLE_BITS-1:0] r_ovol;
    logic                   r_ocal;

    logic [SAMPLE_BITS-1:0] w_pk;
    logic [SAMPLE_BITS-1:0] w_tr;
    logic [SAMPLE_BITS-1:0] w_vol;
    logic [BSUM_W-1:0]      w_bsum;
    logic                   w_blk_full;
    logic [PTR_W-1:0]       w_ptr_nxt;
    logic [AMUL_W-1:0]      w_amul;
    logic [SAMPLE_BITS-1:0] w_avg;
    logic [RS_W-1:0]        w_rs;
    logic [PMUL_W-1:0]      w_pmul;
    logic [LO_W-1:0]        w_bound;
    logic signed [DS_W-1:0] w_num;
    logic signed [DS_W-1:0] w_den;
    logic [DS_W-1:0]        w_num_u;
    logic [DS_W-1:0]        w_den_u;
    logic [DS_W-1:0]        w_mag_n;
    logic [DS_W-1:0]        w_mag_d;
    logic                   w_num_neg;
    logic                   w_num_zero;
    logic                   w_den_zero;
    logic                   w_opp;
    logic                   w_direct;
    logic [BRIGHT_W-1:0]    w_dir_val;
    logic [BD_W-1:0]        w_bd;

    logic                   w_div_start;
    logic [STEP_W-1:0]      w_div_steps;
    logic [DS_W-1:0]        w_div_rem;
    logic [DV_W-1:0]        w_div_quo;
    logic [DS_W-1:0]        w_div_dvs;
    logic                   w_div_idle;
    logic [DV_W-1:0]        w_quo;

    // envelope of the period including the current sample
    always_comb begin
        w_pk  = (i_sample > r_pk) ? i_sample : r_pk;
        w_tr  = (i_sample < r_tr) ? i_sample : r_tr;
        w_vol = (w_pk >= w_tr) ? (w_pk - w_tr) : '0;
    end

    always_comb begin
        w_bsum     = r_bsum + BSUM_W'(r_vol);
        w_blk_full = (r_cnt == CNT_W'(PERIODS_PER_AVERAGE - 1));
        w_ptr_nxt  = (r_ptr == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : r_ptr + 1'b1;
        w_amul     = AMUL_W'(r_bsum) * AMUL_W'(AVG_RCP);
        w_avg      = w_amul[AVG_SH +: SAMPLE_BITS];
        w_rs       = r_fill ? (r_rs + RS_W'(w_avg))
                            : (r_rs - RS_W'(r_rd) + RS_W'(w_avg));
        w_pmul     = PMUL_W'(r_prod) * PMUL_W'(PCT_RCP);
        w_bound    = w_pmul[PCT_SH +: LO_W];
    end

    // span and brightness decision
    always_comb begin
        w_num      = $signed(DS_W'(r_x)) - $signed(DS_W'(r_lo));
        w_den      = $signed(DS_W'(r_hi)) - $signed(DS_W'(r_lo));
        w_num_u    = r_num;
        w_den_u    = r_den;
        w_num_neg  = r_num[DS_W-1];
        w_num_zero = (r_num == '0);
        w_den_zero = (r_den == '0);
        w_opp      = r_num[DS_W-1] ^ r_den[DS_W-1];
        w_mag_n    = w_num_neg ? ('0 - w_num_u) : w_num_u;
        w_mag_d    = r_den[DS_W-1] ? ('0 - w_den_u) : w_den_u;
        w_direct   = w_den_zero || w_num_zero || w_opp || (w_mag_n >= w_mag_d);
        if (w_den_zero) begin
            w_dir_val = (w_num_neg || w_num_zero) ? BRIGHT_ZERO : BRIGHT_MAX;
        end else begin
            w_dir_val = (w_num_zero || w_opp) ? BRIGHT_ZERO : BRIGHT_MAX;
        end
        // magnitude times full scale
        w_bd = {w_mag_n, {BRIGHT_W{1'b0}}} - {{BRIGHT_W{1'b0}}, w_mag_n};
    end

    // divider operands: brightness quotient only
    always_comb begin
        w_div_start = i_cmd.br_eval && !w_direct;
        w_div_steps = STEP_W'(BRIGHT_W);
        w_div_rem   = w_bd[BD_W-1:BRIGHT_W];
        w_div_quo   = w_bd[BRIGHT_W-1:0];
        w_div_dvs   = w_mag_d;
    end

    aalb_div #(
        .DV_W   (DV_W),
        .DS_W   (DS_W),
        .STEP_W (STEP_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_steps (w_div_steps),
        .i_rem   (w_div_rem),
        .i_quo   (w_div_quo),
        .i_dvs   (w_div_dvs),
        .o_idle  (w_div_idle),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valley <= VALLEY_RST;
            r_peak   <= PEAK_RST;
            r_pk     <= '0;
            r_tr     <= '1;
            r_bsum   <= '0;
            r_cnt    <= '0;
            r_ptr    <= '0;
            r_rs     <= '0;
            r_fill   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_VALLEY: r_valley <= i_cfg.data;
                    REG_PEAK:   r_peak   <= i_cfg.data;
                    default:    ;
                endcase
            end
            if (i_cmd.accept) begin
                if (i_period_end) begin
                    r_pk <= '0;
                    r_tr <= '1;
                end else begin
                    r_pk <= w_pk;
                    r_tr <= w_tr;
                end
            end
            // a full block keeps its sum until the window update has averaged it
            if (i_cmd.blk_step) begin
                r_bsum <= w_bsum;
                if (w_blk_full) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.win_update) begin
                r_bsum <= '0;
                r_rs   <= w_rs;
                r_ptr  <= w_ptr_nxt;
                if (w_ptr_nxt == '0) begin
                    r_fill <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_period_end) begin
            r_vol <= w_vol;
            r_cal <= r_fill;
            if (r_fill) begin
                r_bright <= BRIGHT_MAX;
            end
        end
        if (i_cmd.lo_start) begin
            r_x    <= RS_W'(r_vol * WINDOW_LENGTH);
            r_prod <= PROD_W'(r_rs) * PROD_W'(r_valley);
        end
        if (i_cmd.lo_take) begin
            r_lo <= w_bound;
        end
        if (i_cmd.hi_start) begin
            r_prod <= PROD_W'(r_rs) * PROD_W'(r_peak);
        end
        if (i_cmd.hi_take) begin
            r_hi <= w_bound;
        end
        if (i_cmd.span_load) begin
            r_num <= w_num;
            r_den <= w_den;
        end
        if (i_cmd.br_eval && w_direct) begin
            r_bright <= w_dir_val;
        end
        if (i_cmd.br_take) begin
            r_bright <= w_quo[BRIGHT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_obright <= r_bright;
            r_ovol    <= r_vol;
            r_ocal    <= r_cal;
        end
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_step && w_blk_full) begin
            r_rd <= r_win[r_ptr];
        end
        if (i_cmd.win_update) begin
            r_win[r_ptr] <= w_avg;
        end
    end

    assign o_sts.fill      = r_fill;
    assign o_sts.div_idle  = w_div_idle;
    assign o_sts.br_direct = w_direct;
    assign o_sts.blk_full  = w_blk_full;
    assign o_sts.out_free  = !r_ovalid || o_out.ready;

    assign o_out.valid       = r_ovalid;
    assign o_out.brightness  = r_obright;
    assign o_out.volume      = r_ovol;
    assign o_out.calibrating = r_ocal;
    assign i_cfg.ready       = 1'b1;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(WINDOW_LENGTH - 1))
        else $error("window pointer out of range");

    a_fill_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fill |=> !r_fill)
        else $error("calibration restarted");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || o_out.ready))
        else $error("output register overwritten");

    a_cal_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ocal |-> (r_obright == BRIGHT_MAX))
        else $error("calibration item without full brightness");

endmodule

FILE: rtl/core/aalb_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences bounds, brightness, block average and window update per period.
module aalb_ctrl import aalb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_period_end,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LO    = 11'b000_0000_0010,
        S_LO_W  = 11'b000_0000_0100,
        S_HI    = 11'b000_0000_1000,
        S_HI_W  = 11'b000_0001_0000,
        S_SPAN  = 11'b000_0010_0000,
        S_BR    = 11'b000_0100_0000,
        S_BR_W  = 11'b000_1000_0000,
        S_BLK   = 11'b001_0000_0000,
        S_AVG_W = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_period_end) begin
                    n_state = i_sts.fill ? S_BLK : S_LO;
                end
            end
            S_LO: begin
                o_cmd.lo_start = 1'b1;
                n_state        = S_LO_W;
            end
            S_LO_W: begin
                o_cmd.lo_take = 1'b1;
                n_state       = S_HI;
            end
            S_HI: begin
                o_cmd.hi_start = 1'b1;
                n_state        = S_HI_W;
            end
            S_HI_W: begin
                o_cmd.hi_take = 1'b1;
                n_state       = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.span_load = 1'b1;
                n_state         = S_BR;
            end
            S_BR: begin
                o_cmd.br_eval = 1'b1;
                n_state       = i_sts.br_direct ? S_BLK : S_BR_W;
            end
            S_BR_W: begin
                if (i_sts.div_idle) begin
                    o_cmd.br_take = 1'b1;
                    n_state       = S_BLK;
                end
            end
            S_BLK: begin
                o_cmd.blk_step = 1'b1;
                n_state        = i_sts.blk_full ? S_AVG_W : S_OUT;
            end
            S_AVG_W: begin
                o_cmd.win_update = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && i_in_valid && i_period_end |=> !o_in_ready)
        else $error("item taken while a period is in progress");

endmodule

FILE: rtl/core/adaptive_audio_level_brightness_core.sv
`timescale 1ns / 1ps
// Top level: audio level to LED brightness with moving-average gain control.
// A sample without the period-end flag is taken while idle. A period-end item
// is processed one at a time: each bound is a multiply followed by an exact
// reciprocal multiply, the block average is a reciprocal multiply, and only the
// brightness quotient goes through an 8-step bit-serial divider. From acceptance
// an item passes lower bound, upper bound, span, brightness (divider only when not
// settled directly), block step, window update if the period closes an average,
// and output register; during calibration only the last three remain.
// The result waits in an output register while the next samples are accepted.
// Brightness uses the running sum as it stood before the same period's update.
module adaptive_audio_level_brightness_core import aalb_pkg::*; #(
    parameter int WINDOW_LENGTH       = DEF_WINDOW_LENGTH,
    parameter int PERIODS_PER_AVERAGE = DEF_PERIODS_PER_AVERAGE,
    parameter int SAMPLE_BITS         = DEF_SAMPLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aalb_in_if.sink     i_in,
    aalb_out_if.source  o_out,
    aalb_cfg_if.sink    i_cfg
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    aalb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_period_end (i_in.period_end),
        .o_in_ready   (w_in_ready),
        .o_cmd        (w_cmd),
        .i_sts        (w_sts)
    );

    aalb_dp #(
        .WINDOW_LENGTH       (WINDOW_LENGTH),
        .PERIODS_PER_AVERAGE (PERIODS_PER_AVERAGE),
        .SAMPLE_BITS         (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_sample     (i_in.sample),
        .i_period_end (i_in.period_end),
        .o_out        (o_out),
        .i_cfg        (i_cfg)
    );

endmodule
